// ===== hdl/sem_pkg.sv =====
package sem_pkg;

	// input word: item code and grey level
	typedef struct packed {
		logic       func;
		logic [7:0] pixel;
	} sem_in_t;

	// output word: gradient magnitude and frame marker
	typedef struct packed {
		logic [7:0] magnitude;
		logic       last_of_frame;
	} sem_out_t;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_X_KERNEL = 2'd2;
	localparam logic [1:0] REG_Y_KERNEL = 2'd3;

	// item codes
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// register reset values
	localparam logic [9:0]  WIDTH_RST    = 10'd320;
	localparam logic [12:0] HEIGHT_RST   = 13'd320;
	localparam logic [35:0] X_KERNEL_RST = 36'd4548780303;
	localparam logic [35:0] Y_KERNEL_RST = 36'd4848619503;

	localparam logic [12:0] MAX_HEIGHT = 13'd4096;
	localparam logic [12:0] MIN_SIZE   = 13'd3;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic conv;
		logic sq_x;
		logic sq_y;
		logic root_step;
		logic out_load;
	} sem_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;
		logic root_last;
		logic out_free;
	} sem_status_t;

endpackage

// ===== hdl/sobel_edge_magnitude.sv =====
// Sobel edge magnitude over a raster stream of grey pixels.
// Input channel in_valid / in_stall / in_word carries one word per pixel
// position, func selecting an image pixel or a flush position read as zero.
// Output channel out_valid / out_stall / out_word returns the floored
// gradient magnitude (saturated at 255) and a frame end marker.
// Results trail the input by one row plus one position; after a frame the
// source sends one row plus one flush words to drain the last rows.
// Each word holds the block alone: load and shift, and for a result also
// convolution, both squares and the 8-step bit-serial square root.
// A finished result sits in an output register, so a stalled receiver
// holds back the next word only once it also has its result ready.
// The configuration port (cfg_valid / cfg_ready, index, data) is always
// ready; the user is to write it while the block is idle, as nothing in it checks.
// Reset clears counters, window and configuration to their defaults;
// the line stores are undefined until written.
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sem_pkg::sem_in_t  in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output sem_pkg::sem_out_t out_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [35:0]       cfg_data
);

	sem_pkg::sem_cmd_t    cmd;
	sem_pkg::sem_status_t st;

	assign cfg_ready = 1'b1;

	// sequencer
	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// line stores, window and arithmetic
	sem_dpath #(.MAX_WIDTH(MAX_WIDTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== hdl/sem_ctrl.sv =====
module sem_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sem_pkg::sem_status_t  st,
	output sem_pkg::sem_cmd_t     cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_CONV  = 3'd2;
	localparam logic [2:0] S_SQX   = 3'd3;
	localparam logic [2:0] S_SQY   = 3'd4;
	localparam logic [2:0] S_ROOT  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_n;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_n = st.emit ? S_CONV : S_IDLE;
			end
			S_CONV: begin
				cmd.conv = 1'b1;
				state_n = S_SQX;
			end
			S_SQX: begin
				cmd.sq_x = 1'b1;
				state_n = S_SQY;
			end
			S_SQY: begin
				cmd.sq_y = 1'b1;
				state_n = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (st.root_last) state_n = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

endmodule

// ===== hdl/sem_dpath.sv =====
module sem_dpath #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sem_pkg::sem_in_t      in_word,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [35:0]           cfg_data,
	input  sem_pkg::sem_cmd_t     cmd,
	output sem_pkg::sem_status_t  st,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sem_pkg::sem_out_t     out_word
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
	localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

	// configuration registers
	logic [9:0]  width_q;
	logic [12:0] height_q;
	logic [35:0] xk_q;
	logic [35:0] yk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::WIDTH_RST;
			height_q <= sem_pkg::HEIGHT_RST;
			xk_q     <= sem_pkg::X_KERNEL_RST;
			yk_q     <= sem_pkg::Y_KERNEL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sem_pkg::REG_WIDTH:    width_q  <= cfg_data[9:0];
				sem_pkg::REG_HEIGHT:   height_q <= cfg_data[12:0];
				sem_pkg::REG_X_KERNEL: xk_q     <= cfg_data;
				sem_pkg::REG_Y_KERNEL: yk_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame size
	logic [EW-1:0] w_eff;
	logic [12:0]   h_eff;
	always_comb begin
		w_eff = EW'(width_q);
		if (w_eff < EW'(3)) w_eff = EW'(3);
		if (w_eff > MAXW) w_eff = MAXW;
		h_eff = height_q;
		if (h_eff < sem_pkg::MIN_SIZE) h_eff = sem_pkg::MIN_SIZE;
		if (h_eff > sem_pkg::MAX_HEIGHT) h_eff = sem_pkg::MAX_HEIGHT;
	end

	// input position; row count saturates at two
	logic [CW-1:0] in_col_q;
	logic [1:0]    in_row_q;
	logic [CW-1:0] out_col_q;
	logic [11:0]   out_row_q;
	logic [CW-1:0] col_clamp;
	logic [CW-1:0] col_s1;
	logic [7:0]    px_s1;
	logic [7:0]    rd0_s1;
	logic [7:0]    rd1_s1;

	assign col_clamp = (EW'(in_col_q) >= w_eff) ? '0 : in_col_q;

	// line stores, two rows
	logic [7:0] mem0 [MAX_WIDTH];
	logic [7:0] mem1 [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd0_s1 <= mem0[col_clamp];
			rd1_s1 <= mem1[col_clamp];
		end
		if (cmd.shift) begin
			mem0[col_s1] <= rd1_s1;
			mem1[col_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_s1 <= col_clamp;
			px_s1  <= (in_word.func == sem_pkg::FUNC_FLUSH) ? 8'd0 : in_word.pixel;
		end
	end

	assign st.emit = (in_row_q == 2'd2) || (in_row_q == 2'd1 && col_s1 != '0);

	// 3x3 window
	logic [7:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
		end else if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd0_s1;
			win_q[1][2] <= rd1_s1;
			win_q[2][2] <= px_s1;
		end
	end

	// clamped output position and frame end
	logic [CW-1:0] c_cl;
	logic [11:0]   r_cl;
	logic          last;
	always_comb begin
		c_cl = (EW'(out_col_q) >= w_eff) ? CW'(w_eff - EW'(1)) : out_col_q;
		r_cl = (13'(out_row_q) >= h_eff) ? 12'(h_eff - 13'd1) : out_row_q;
		last = (13'(r_cl) == h_eff - 13'd1) && (EW'(c_cl) == w_eff - EW'(1));
	end

	// convolution with border masking
	logic signed [15:0] gx_n;
	logic signed [15:0] gy_n;
	always_comb begin
		logic signed [15:0] pv;
		logic signed [15:0] kx;
		logic signed [15:0] ky;
		logic               use_it;
		int unsigned        ci;
		gx_n = '0;
		gy_n = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				use_it = 1'b1;
				if (i == 0 && r_cl == '0) use_it = 1'b0;
				if (i == 2 && 13'(r_cl) + 13'd1 >= h_eff) use_it = 1'b0;
				if (j == 0 && c_cl == '0) use_it = 1'b0;
				if (j == 2 && EW'(c_cl) + EW'(1) >= w_eff) use_it = 1'b0;
				ci = (2 - i) * 3 + (2 - j);
				pv = signed'(16'(win_q[i][j]));
				kx = 16'(signed'(xk_q[4*ci +: 4]));
				ky = 16'(signed'(yk_q[4*ci +: 4]));
				if (use_it) begin
					gx_n = gx_n + kx * pv;
					gy_n = gy_n + ky * pv;
				end
			end
		end
	end

	// gradient, squares and root
	logic signed [15:0] gx_s2;
	logic signed [15:0] gy_s2;
	logic               last_s2;
	logic [30:0]        sq_s3;
	logic [7:0]         root_q;
	logic [2:0]         bit_q;
	logic [7:0]         trial;
	logic [15:0]        trial_sq;
	logic               sat;

	assign sat      = (sq_s3[30:16] != '0);
	assign trial    = root_q | (8'd1 << bit_q);
	assign trial_sq = 16'(trial) * 16'(trial);
	assign st.root_last = (bit_q == 3'd0);

	always_ff @(posedge clk) begin
		if (cmd.conv) begin
			gx_s2   <= gx_n;
			gy_s2   <= gy_n;
			last_s2 <= last;
		end
		if (cmd.sq_x) sq_s3 <= 31'(unsigned'(32'(gx_s2) * 32'(gx_s2)));
		if (cmd.sq_y) sq_s3 <= sq_s3 + 31'(unsigned'(32'(gy_s2) * 32'(gy_s2)));
		if (cmd.sq_y) begin
			root_q <= '0;
			bit_q  <= 3'd7;
		end else if (cmd.root_step) begin
			if (trial_sq <= sq_s3[15:0]) root_q <= trial;
			bit_q <= bit_q - 3'd1;
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cmd.shift) begin
			if (EW'(col_s1) + EW'(1) >= w_eff) begin
				in_col_q <= '0;
				if (in_row_q != 2'd2) in_row_q <= in_row_q + 2'd1;
			end else begin
				in_col_q <= col_s1 + CW'(1);
			end
		end else if (cmd.conv) begin
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (EW'(c_cl) + EW'(1) >= w_eff) begin
				out_col_q <= '0;
				out_row_q <= r_cl + 12'd1;
			end else begin
				out_col_q <= c_cl + CW'(1);
				out_row_q <= r_cl;
			end
		end
	end

	// output register
	logic              out_valid_q;
	sem_pkg::sem_out_t out_word_q;

	assign st.out_free = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign out_word    = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_word_q.magnitude     <= sat ? 8'd255 : root_q;
			out_word_q.last_of_frame <= last_s2;
		end
	end

endmodule

// ===== hdl/sem_chk.sv =====
module sem_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input sem_pkg::sem_out_t out_word
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	// a stalled result keeps its word
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("result word changed under stall");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while busy");

	// no result appears in the cycle after an accept when none was offered
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind sobel_edge_magnitude sem_chk u_sem_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int LINE_MAX = 512;
	localparam int ROW_MAX  = 4096;

	// predicts the edge magnitudes and matches them against the block
	class sobel_scoreboard;
		bit [7:0]    rows_seen[2*LINE_MAX];
		bit [7:0]    win[3][3];
		int unsigned in_col, in_row, out_col, out_row;
		bit [9:0]    width_reg;
		bit [12:0]   height_reg;
		bit [35:0]   kx_reg, ky_reg;
		sem_pkg::sem_out_t magnitude_q[$];
		int          errors;
		int          results;
		int          frames;

		function new();
			width_reg  = sem_pkg::WIDTH_RST;
			height_reg = sem_pkg::HEIGHT_RST;
			kx_reg     = sem_pkg::X_KERNEL_RST;
			ky_reg     = sem_pkg::Y_KERNEL_RST;
		endfunction

		function void write_reg(logic [1:0] idx, logic [35:0] data);
			case (idx)
				sem_pkg::REG_WIDTH:    width_reg  = data[9:0];
				sem_pkg::REG_HEIGHT:   height_reg = data[12:0];
				sem_pkg::REG_X_KERNEL: kx_reg     = data;
				sem_pkg::REG_Y_KERNEL: ky_reg     = data;
				default: ;
			endcase
		endfunction

		function int coef(bit [35:0] k, int idx);
			return int'(signed'(k[4*idx +: 4]));
		endfunction

		function int root_floor(int s);
			int r;
			r = 0;
			if (s >= 65536) return 255;
			for (int b = 128; b != 0; b >>= 1)
				if ((r | b) * (r | b) <= s) r = r | b;
			return r;
		endfunction

		// one pixel position: shift window, update line stores, maybe emit
		function void note_word(sem_pkg::sem_in_t w_in);
			int unsigned w, h, col, r, c;
			bit [7:0]    px;
			bit          emit, last;
			int          gx, gy, v, ci;
			sem_pkg::sem_out_t res;
			w = width_reg < 3 ? 3 : (width_reg > LINE_MAX ? LINE_MAX : width_reg);
			h = height_reg < 3 ? 3 : (height_reg > ROW_MAX ? ROW_MAX : height_reg);
			col = in_col >= w ? 0 : in_col;
			px = (w_in.func == sem_pkg::FUNC_FLUSH) ? 8'd0 : w_in.pixel;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = rows_seen[col];
			win[1][2] = rows_seen[LINE_MAX + col];
			win[2][2] = px;
			rows_seen[col] = rows_seen[LINE_MAX + col];
			rows_seen[LINE_MAX + col] = px;
			emit = (in_row >= 2) || (in_row == 1 && col >= 1);
			col++;
			if (col >= w) begin
				col = 0;
				in_row++;
			end
			in_col = col;
			if (!emit) return;
			r = out_row >= h ? h - 1 : out_row;
			c = out_col >= w ? w - 1 : out_col;
			gx = 0;
			gy = 0;
			// flipped kernels, border taps read as zero
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					if ((i == 0 && r == 0) || (i == 2 && r + 1 >= h)) continue;
					if ((j == 0 && c == 0) || (j == 2 && c + 1 >= w)) continue;
					v = win[i][j];
					ci = (2 - i) * 3 + (2 - j);
					gx += coef(kx_reg, ci) * v;
					gy += coef(ky_reg, ci) * v;
				end
			last = (r == h - 1) && (c == w - 1);
			res.magnitude = 8'(root_floor(gx * gx + gy * gy));
			res.last_of_frame = last;
			magnitude_q.push_back(res);
			if (last) begin
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
				frames++;
			end else begin
				c++;
				if (c >= w) begin
					c = 0;
					r++;
				end
				out_col = c;
				out_row = r;
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_word(sem_pkg::sem_out_t got);
			sem_pkg::sem_out_t want;
			if (magnitude_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word mag=%0d last=%0b",
					got.magnitude, got.last_of_frame));
				return;
			end
			want = magnitude_q.pop_front();
			results++;
			if (got.magnitude !== want.magnitude)
				report_mismatch($sformatf("result %0d magnitude %0d, want %0d",
					results, got.magnitude, want.magnitude));
			if (got.last_of_frame !== want.last_of_frame)
				report_mismatch($sformatf("result %0d last_of_frame %0b, want %0b",
					results, got.last_of_frame, want.last_of_frame));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	sem_pkg::sem_in_t  in_word;
	logic              out_valid;
	logic              out_stall;
	sem_pkg::sem_out_t out_word;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [35:0]       cfg_data;

	sobel_scoreboard sb = new();
	sem_pkg::sem_in_t pixel_q[$];
	int      burst_left;
	int      gap_left;
	int      stall_mode;
	int      stall_len;
	int      sent;

	sobel_edge_magnitude dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sender: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_word    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pixel_q.size() > 0) begin
				in_valid <= 1'b1;
				in_word  <= pixel_q.pop_front();
				if (burst_left == 0)
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
						: $urandom_range(1, 20);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern changes mode every so often
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode = 0;
			stall_len  = 0;
		end else begin
			if (stall_len == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_len  = $urandom_range(20, 400);
			end
			stall_len--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= (stall_len % 3 == 0);
				2: out_stall <= ($urandom_range(0, 9) < 6);
				default: out_stall <= ((stall_len / 17) % 2 == 1);
			endcase
		end
	end

	// monitor: every handshake sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) sb.note_word(in_word);
			if (out_valid && !out_stall) sb.check_word(out_word);
		end
	end

	task write_cfg(logic [1:0] idx, logic [35:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task wait_idle();
		while (pixel_q.size() > 0 || in_valid || sb.magnitude_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// pixel pattern: 0 random, 1 all max, 2 checkerboard extremes
	task run_frame(bit [9:0] w, bit [12:0] h, bit [35:0] kx, bit [35:0] ky,
			int pattern, int flush_odds);
		int unsigned ew, eh;
		sem_pkg::sem_in_t wd;
		write_cfg(sem_pkg::REG_WIDTH, 36'(w));
		write_cfg(sem_pkg::REG_HEIGHT, 36'(h));
		write_cfg(sem_pkg::REG_X_KERNEL, kx);
		write_cfg(sem_pkg::REG_Y_KERNEL, ky);
		ew = w < 3 ? 3 : (w > LINE_MAX ? LINE_MAX : w);
		eh = h < 3 ? 3 : (h > ROW_MAX ? ROW_MAX : h);
		for (int unsigned n = 0; n < ew * eh + ew + 1; n++) begin
			wd.pixel = 8'($urandom_range(0, 255));
			if (n >= ew * eh)
				wd.func = sem_pkg::FUNC_FLUSH;
			else if (flush_odds > 0 && $urandom_range(1, flush_odds) == 1)
				wd.func = sem_pkg::FUNC_FLUSH;
			else begin
				wd.func = sem_pkg::FUNC_PIXEL;
				if (pattern == 1) wd.pixel = 8'hff;
				if (pattern == 2) wd.pixel = ((n + n / ew) % 2) ? 8'hff : 8'h00;
			end
			pixel_q.push_back(wd);
		end
		sent += ew * eh + ew + 1;
		wait_idle();
	endtask

	initial begin
		bit [9:0]    w;
		bit [12:0]   h;
		bit [35:0]   kx, ky;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sem_pkg::REG_WIDTH;
		cfg_data  = '0;
		sent      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clamped sizes, saturating kernels, extreme frames
		run_frame(10'd0, 13'd1, sem_pkg::X_KERNEL_RST, sem_pkg::Y_KERNEL_RST, 2, 0);
		run_frame(10'd2, 13'd2, sem_pkg::X_KERNEL_RST, sem_pkg::Y_KERNEL_RST, 1, 3);
		run_frame(10'd5, 13'd4, 36'h777777777, 36'h777777777, 1, 0);
		run_frame(10'd4, 13'd3, 36'h888888888, 36'h000000000, 2, 0);
		run_frame(10'd3, 13'd3, 36'h000000000, 36'hfffffffff, 0, 0);
		run_frame(10'd40, 13'd0, sem_pkg::X_KERNEL_RST, sem_pkg::Y_KERNEL_RST, 0, 40);
		run_frame(10'd16, 13'd3, 36'h888888888, 36'h777777777, 2, 0);
		run_frame(10'd3, 13'd60, sem_pkg::X_KERNEL_RST, sem_pkg::Y_KERNEL_RST, 0, 50);

		// random frames, mostly small
		while (sent < 1900) begin
			w = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 2))
				: 10'($urandom_range(3, 12));
			h = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2))
				: 13'($urandom_range(3, 6));
			if ($urandom_range(0, 2) == 0) begin
				kx = sem_pkg::X_KERNEL_RST;
				ky = sem_pkg::Y_KERNEL_RST;
			end else begin
				kx = {4'($urandom_range(0, 15)), $urandom()};
				ky = {4'($urandom_range(0, 15)), $urandom()};
			end
			run_frame(w, h, kx, ky, ($urandom_range(0, 9) == 0) ? 1 : 0,
				($urandom_range(0, 1) == 0) ? 0 : 20);
		end

		$display("covered %0d words, %0d frames, %0d magnitudes checked",
			sent, sb.frames, sb.results);
		$display("sizes from clamped 3x3 up to 40 wide and 60 tall, fixed and random kernels");
		if (sb.errors == 0)
			$display("PASS sobel_edge_magnitude");
		else
			$display("FAIL sobel_edge_magnitude");
		$finish;
	end

	// hang guard
	initial begin
		#50ms;
		$display("timeout with %0d results pending", sb.magnitude_q.size());
		$display("FAIL sobel_edge_magnitude");
		$finish;
	end

endmodule
